@@ rtl/sitda_pkg.sv @@
// shared constants, types and state encoding for the signed integer to decimal text converter
// no dependencies
package sitda_pkg;

    // width of the signed input value
    localparam int WIDTH = 32;
    // decimal digits needed for a magnitude of up to 2^(WIDTH-1)
    localparam int DIGITS = (WIDTH * 302) / 1000 + 1;
    localparam int BCD_W = DIGITS * 4;
    localparam int STEP_W = $clog2(WIDTH);
    localparam int DCNT_W = $clog2(DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    // commands from the sequencer to the shift-add-3 unit
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_dd_cmd;

endpackage

@@ rtl/sitda_in_if.sv @@
// request channel carrying one signed value
// depends on sitda_pkg
interface sitda_in_if;
    import sitda_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

@@ rtl/sitda_out_if.sv @@
// character channel carrying one ascii character and its last flag
// depends on sitda_pkg
interface sitda_out_if;
    import sitda_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

@@ rtl/sitda_dabble.sv @@
// shift-add-3 unit: one binary to bcd step per cycle, plus digit shift-out for emission
// depends on sitda_pkg
module sitda_dabble (
    input  logic                          i_clk,
    input  sitda_pkg::t_dd_cmd            i_cmd,
    input  logic [sitda_pkg::WIDTH-1:0]   i_mag,
    output logic [3:0]                    o_top_digit
);
    import sitda_pkg::*;

    logic [WIDTH-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            {r_bcd, r_bin} <= {w_adj[BCD_W-2:0], r_bin, 1'b0};
        end else if (i_cmd.shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];
endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// top level: signed integer to decimal ascii text converter
// depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_dabble
//
// usage
//   i_in carries one signed WIDTH-bit value per request. o_out returns its
//   decimal text one character per request, most significant digit first,
//   a leading '-' for negative values, and last set on the final digit.
//   zero gives the single character '0'; the most negative value gives its
//   exact digits. no terminator is sent.
// operation
//   after acceptance the shift-add-3 unit takes one input bit per cycle,
//   then leading zero digits are dropped one per cycle, then one character
//   leaves per cycle while o_out.ready stays high: sign plus digits.
//   i_in.ready is high only while the sequencer is idle; the conversion
//   loop through the shared unit sets the rate.
// reset
//   i_rst_n is synchronous and active low; it returns the sequencer to idle
//   and drops o_out.valid. digit storage is not cleared.
// stalls
//   characters sit in an output register; while o_out.ready is low the
//   character holds and the sequencer waits. the last character may still
//   wait while the next request is already taken.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitda_in_if.sink    i_in,
    sitda_out_if.source o_out
);
    import sitda_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DCNT_W-1:0] r_digits, n_digits;
    logic              r_neg, n_neg;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;

    t_dd_cmd           w_cmd;
    logic [WIDTH-1:0]  w_mag;
    logic [3:0]        w_top;
    logic              w_out_free;

    // magnitude as an unsigned value, exact also for the most negative value
    assign w_mag = i_in.value[WIDTH-1] ? (~i_in.value + 1'b1) : i_in.value;

    sitda_dabble u_dabble (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    // output register is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_digits    = r_digits;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        w_cmd       = '0;
        i_in.ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    w_cmd.load = 1'b1;
                    n_neg      = i_in.value[WIDTH-1];
                    n_step     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                w_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(WIDTH - 1)) begin
                    n_digits = DCNT_W'(DIGITS);
                    n_state  = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_top == 4'd0 && r_digits != DCNT_W'(1)) begin
                    w_cmd.shift = 1'b1;
                    n_digits    = r_digits - 1'b1;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_ZERO + {4'd0, w_top};
                    n_last      = (r_digits == DCNT_W'(1));
                    w_cmd.shift = 1'b1;
                    n_digits    = r_digits - 1'b1;
                    if (r_digits == DCNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_digits    <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_digits    <= n_digits;
            r_neg       <= n_neg;
        end
    end

    // character payload
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;
endmodule

@@ rtl/sitda_check.sv @@
// port-level checker for the converter, bound to the top level
// depends on signed_int_to_decimal_ascii and its interfaces
module sitda_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_character,
    input logic       i_out_last
);
    // only a sign or a decimal digit ever leaves
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_character == 8'd45 ||
                         (i_out_character >= 8'd48 && i_out_character <= 8'd57)))
        else $error("character outside sign and digits");

    // a sign is always followed by digits
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_character == 8'd45) |-> !i_out_last)
        else $error("sign flagged as last");

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after acceptance");

    // stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_character) && $stable(i_out_last)))
        else $error("stalled character changed");
endmodule

bind signed_int_to_decimal_ascii sitda_check u_sitda_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);
